### src/mlfq_pkg.sv
// Shared constants, types and helper functions of the feedback queue scheduler.
`timescale 1ns / 1ps
package mlfq_pkg;

   localparam int MAX_PROCS = 64;
   localparam int PIX_W     = $clog2(MAX_PROCS);
   localparam int WALK_W    = $clog2(MAX_PROCS + 1);

   localparam int ID_W      = 6;
   localparam int QUANT_W   = 12;
   localparam int BURST_W   = 20;
   localparam int SLICE_W   = 14;
   localparam int WAIT_W    = 32;
   localparam int LEVEL_W   = 2;
   localparam int CNT_W     = 7;
   localparam int QPOS_W    = 6;
   localparam int QADDR_W   = LEVEL_W + QPOS_W;
   localparam int QDEPTH    = 1 << QADDR_W;
   localparam int NUM_LEVELS = 4;

   localparam logic [CNT_W-1:0]   QUEUE_CAP   = 7'd64;
   localparam logic [QUANT_W-1:0] QUANT_RESET = 12'd8;
   localparam logic [LEVEL_W-1:0] LEVEL_TOP   = 2'd0;
   localparam logic [LEVEL_W-1:0] LEVEL_LOW   = 2'd3;

   localparam logic [2:0] OP_ADMIT    = 3'd0;
   localparam logic [2:0] OP_READY    = 3'd1;
   localparam logic [2:0] OP_DISPATCH = 3'd2;
   localparam logic [2:0] OP_SLICE    = 3'd3;
   localparam logic [2:0] OP_EXIT     = 3'd4;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_ERR   = 2'd2;

   typedef enum logic [3:0] {
      S_IDLE,
      S_RDY,
      S_SL_WALK,
      S_SL_RD,
      S_SL_UPD,
      S_DP_Q,
      S_DP_P,
      S_SH,
      S_AG_BEGIN,
      S_AG_NEXT,
      S_AG_Q,
      S_AG_P,
      S_AG_APP
   } state_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] level;
      logic [WAIT_W-1:0]  wait_cnt;
   } pent_type;

   localparam int PENT_W = $bits(pent_type);

   typedef struct packed {
      logic               we;
      logic [QADDR_W-1:0] waddr;
      logic [ID_W-1:0]    wdata;
      logic [QADDR_W-1:0] raddr;
   } qmem_req_type;

   typedef struct packed {
      logic             we;
      logic [PIX_W-1:0] waddr;
      pent_type         wdata;
      logic [PIX_W-1:0] raddr;
   } pmem_req_type;

   // quantum times (level + 1)
   function automatic logic [SLICE_W-1:0] slice_len(input logic [QUANT_W-1:0] q,
                                                    input logic [LEVEL_W-1:0] lv);
      logic [2:0] m;
      m = {1'b0, lv} + 3'd1;
      return SLICE_W'(q) * SLICE_W'(m);
   endfunction

   function automatic logic id_ok(input logic [ID_W-1:0] id);
      return (32'(id) < MAX_PROCS);
   endfunction

   function automatic logic [WAIT_W-1:0] sat_add(input logic [WAIT_W-1:0] w,
                                                 input logic [BURST_W-1:0] b);
      logic [WAIT_W:0] s;
      s = {1'b0, w} + (WAIT_W + 1)'(b);
      return s[WAIT_W] ? {WAIT_W{1'b1}} : s[WAIT_W-1:0];
   endfunction

endpackage

### src/mlfq_ram.sv
// Simple dual-port RAM with registered read data.
`timescale 1ns / 1ps
module mlfq_ram #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 8,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### src/mlfq_ctrl.sv
// Sequencer and shared datapath: process table walk, queue shifting and aging.
`timescale 1ns / 1ps
module mlfq_ctrl import mlfq_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_op,
   input  logic [ID_W-1:0]    req_proc_id,
   input  logic [BURST_W-1:0] req_burst_cycles,
   input  logic               req_requeue,
   output logic               rsp_valid,
   output logic [ID_W-1:0]    rsp_granted_id,
   output logic [SLICE_W-1:0] rsp_slice_length,
   output logic [1:0]         rsp_status,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [QUANT_W-1:0] csr_data,
   output qmem_req_type       q_req,
   input  logic [ID_W-1:0]    q_rdata,
   output pmem_req_type       p_req,
   input  pent_type           p_rdata
);

   state_type state_ff, state_in, ret_ff, ret_in;
   logic [QUANT_W-1:0] quant_ff, quant_in;
   logic [CNT_W-1:0]   cnt_ff [NUM_LEVELS];
   logic [CNT_W-1:0]   cnt_in [NUM_LEVELS];
   logic [MAX_PROCS-1:0] active_ff, active_in;
   logic [MAX_PROCS-1:0] pvalid_ff;
   logic               prv_ff;
   logic               rsp_valid_ff, rsp_valid_in;

   logic [ID_W-1:0]    id_ff, id_in;
   logic [BURST_W-1:0] burst_ff, burst_in;
   logic               req_ff, req_in;
   logic [LEVEL_W-1:0] lv_ff, lv_in;
   logic [CNT_W-1:0]   pos_ff, pos_in;
   logic [WALK_W-1:0]  walk_ff, walk_in;
   logic [LEVEL_W-1:0] age_lv_ff, age_lv_in;
   logic [ID_W-1:0]    ent_id_ff, ent_id_in;
   logic [LEVEL_W-1:0] newlv_ff, newlv_in;
   logic [ID_W-1:0]    granted_ff, granted_in;
   logic [SLICE_W-1:0] slice_ff, slice_in;
   logic               sh_v_ff, sh_v_in;
   logic [ID_W-1:0]    rsp_gid_ff, rsp_gid_in;
   logic [SLICE_W-1:0] rsp_slice_ff, rsp_slice_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;

   // shared conditions
   pent_type           prd;
   logic [PIX_W-1:0]   pid_in, pid_ff, wprev;
   logic               in_bad, in_act, any_ne;
   logic [LEVEL_W-1:0] first_lv;
   logic               rdy_full;
   logic               promote, sl_full;
   logic [LEVEL_W-1:0] sl_nl;
   logic [CNT_W-1:0]   sh_pos_n, sh_rd_pos;
   logic               sh_rd;
   logic               ag_has, ag_old, ag_full, ag_last;
   logic [LEVEL_W-1:0] ag_nl;
   logic [SLICE_W:0]   ag_limit;
   logic               walk_end;
   logic               fin;
   logic [1:0]         fin_st;

   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;

   always_comb begin
      prd      = prv_ff ? p_rdata : '0;
      pid_in   = PIX_W'(req_proc_id);
      pid_ff   = PIX_W'(id_ff);
      wprev    = PIX_W'(walk_ff - WALK_W'(1));
      in_bad   = (req_op > OP_EXIT) || !id_ok(req_proc_id);
      in_act   = active_ff[pid_in];
      any_ne   = 1'b0;
      first_lv = LEVEL_TOP;
      for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
         if (cnt_ff[i] != '0) begin
            any_ne   = 1'b1;
            first_lv = LEVEL_W'(i);
         end
      end
      rdy_full  = (cnt_ff[prd.level] >= QUEUE_CAP);
      promote   = (prd.level < LEVEL_LOW) &&
                  (burst_ff >= BURST_W'(slice_len(quant_ff, prd.level)));
      sl_nl     = promote ? prd.level + 2'd1 : prd.level;
      sl_full   = (cnt_ff[sl_nl] >= QUEUE_CAP);
      sh_pos_n  = sh_v_ff ? pos_ff + 7'd1 : pos_ff;
      sh_rd_pos = sh_pos_n + 7'd1;
      sh_rd     = (sh_rd_pos < cnt_ff[lv_ff]);
      ag_has    = (pos_ff < cnt_ff[age_lv_ff]);
      ag_limit  = {slice_len(quant_ff, prd.level), 1'b0};
      ag_old    = (prd.wait_cnt >= WAIT_W'(ag_limit));
      ag_nl     = (prd.level != LEVEL_TOP) ? prd.level - 2'd1 : LEVEL_TOP;
      ag_full   = (cnt_ff[ag_nl] >= QUEUE_CAP);
      ag_last   = (age_lv_ff == LEVEL_LOW);
      walk_end  = (walk_ff == WALK_W'(MAX_PROCS));
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (req_op == OP_DISPATCH) begin
                  state_in = any_ne ? S_DP_Q : S_IDLE;
               end else if (in_bad || req_op == OP_ADMIT || !in_act || req_op == OP_EXIT) begin
                  state_in = S_IDLE;
               end else if (req_op == OP_READY) begin
                  state_in = S_RDY;
               end else begin
                  state_in = S_SL_WALK;
               end
            end
         end
         S_RDY:      state_in = S_IDLE;
         S_SL_WALK:  state_in = walk_end ? S_SL_RD : S_SL_WALK;
         S_SL_RD:    state_in = S_SL_UPD;
         S_SL_UPD:   state_in = S_IDLE;
         S_DP_Q:     state_in = S_DP_P;
         S_DP_P:     state_in = S_SH;
         S_SH:       state_in = sh_rd ? S_SH : ret_ff;
         S_AG_BEGIN: state_in = S_AG_NEXT;
         S_AG_NEXT: begin
            if (ag_has) begin
               state_in = S_AG_Q;
            end else begin
               state_in = ag_last ? S_IDLE : S_AG_NEXT;
            end
         end
         S_AG_Q:     state_in = id_ok(q_rdata) ? S_AG_P : S_AG_NEXT;
         S_AG_P: begin
            if (ag_old) begin
               if (ag_full) begin
                  state_in = ag_last ? S_IDLE : S_AG_NEXT;
               end else begin
                  state_in = S_SH;
               end
            end else begin
               state_in = S_AG_NEXT;
            end
         end
         S_AG_APP:   state_in = ag_last ? S_IDLE : S_AG_NEXT;
         default:    state_in = S_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      q_req      = '0;
      p_req      = '0;
      fin        = 1'b0;
      fin_st     = ST_OK;
      cnt_in     = cnt_ff;
      active_in  = active_ff;
      id_in      = id_ff;
      burst_in   = burst_ff;
      req_in     = req_ff;
      lv_in      = lv_ff;
      pos_in     = pos_ff;
      walk_in    = walk_ff;
      age_lv_in  = age_lv_ff;
      ent_id_in  = ent_id_ff;
      newlv_in   = newlv_ff;
      granted_in = granted_ff;
      slice_in   = slice_ff;
      sh_v_in    = sh_v_ff;
      ret_in     = ret_ff;
      quant_in   = csr_valid ? csr_data : quant_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               id_in      = req_proc_id;
               burst_in   = req_burst_cycles;
               req_in     = req_requeue;
               granted_in = '0;
               slice_in   = '0;
               walk_in    = '0;
               if (req_op == OP_DISPATCH) begin
                  if (any_ne) begin
                     lv_in       = first_lv;
                     q_req.raddr = {first_lv, QPOS_W'(0)};
                  end else begin
                     fin    = 1'b1;
                     fin_st = ST_EMPTY;
                  end
               end else if (in_bad) begin
                  fin    = 1'b1;
                  fin_st = ST_ERR;
               end else if (req_op == OP_ADMIT) begin
                  active_in[pid_in] = 1'b1;
                  p_req.we    = 1'b1;
                  p_req.waddr = pid_in;
                  p_req.wdata = '0;
                  fin         = 1'b1;
               end else if (!in_act) begin
                  fin    = 1'b1;
                  fin_st = ST_ERR;
               end else if (req_op == OP_READY) begin
                  p_req.raddr = pid_in;
               end else if (req_op == OP_EXIT) begin
                  active_in[pid_in] = 1'b0;
                  fin = 1'b1;
               end
            end
         end
         S_RDY: begin
            fin = 1'b1;
            if (rdy_full) begin
               fin_st = ST_ERR;
            end else begin
               q_req.we    = 1'b1;
               q_req.waddr = {prd.level, cnt_ff[prd.level][QPOS_W-1:0]};
               q_req.wdata = id_ff;
               cnt_in[prd.level] = cnt_ff[prd.level] + 7'd1;
               p_req.we    = 1'b1;
               p_req.waddr = pid_ff;
               p_req.wdata = '{level: prd.level, wait_cnt: '0};
            end
         end
         S_SL_WALK: begin
            // read entry walk, write back entry walk-1, read in the previous cycle
            if (!walk_end) begin
               p_req.raddr = PIX_W'(walk_ff);
               walk_in     = walk_ff + WALK_W'(1);
            end
            if (walk_ff != '0 && active_ff[wprev]) begin
               p_req.we    = 1'b1;
               p_req.waddr = wprev;
               p_req.wdata = '{level: prd.level, wait_cnt: sat_add(prd.wait_cnt, burst_ff)};
            end
         end
         S_SL_RD: begin
            p_req.raddr = pid_ff;
         end
         S_SL_UPD: begin
            fin         = 1'b1;
            p_req.we    = 1'b1;
            p_req.waddr = pid_ff;
            if (req_ff && !sl_full) begin
               q_req.we    = 1'b1;
               q_req.waddr = {sl_nl, cnt_ff[sl_nl][QPOS_W-1:0]};
               q_req.wdata = id_ff;
               cnt_in[sl_nl] = cnt_ff[sl_nl] + 7'd1;
               p_req.wdata = '{level: sl_nl, wait_cnt: '0};
            end else begin
               p_req.wdata = '{level: sl_nl, wait_cnt: prd.wait_cnt};
               fin_st      = req_ff ? ST_ERR : ST_OK;
            end
         end
         S_DP_Q: begin
            granted_in  = q_rdata;
            p_req.raddr = PIX_W'(q_rdata);
         end
         S_DP_P: begin
            slice_in = id_ok(granted_ff) ? slice_len(quant_ff, prd.level) : '0;
            pos_in   = '0;
            sh_v_in  = 1'b0;
            ret_in   = S_AG_BEGIN;
         end
         S_SH: begin
            // close the gap at pos: move entry pos+1 down, one per cycle
            if (sh_v_ff) begin
               q_req.we    = 1'b1;
               q_req.waddr = {lv_ff, pos_ff[QPOS_W-1:0]};
               q_req.wdata = q_rdata;
            end
            pos_in = sh_pos_n;
            if (sh_rd) begin
               q_req.raddr = {lv_ff, sh_rd_pos[QPOS_W-1:0]};
               sh_v_in     = 1'b1;
            end else begin
               sh_v_in       = 1'b0;
               cnt_in[lv_ff] = cnt_ff[lv_ff] - 7'd1;
            end
         end
         S_AG_BEGIN: begin
            age_lv_in = 2'd1;
            pos_in    = '0;
         end
         S_AG_NEXT: begin
            if (ag_has) begin
               q_req.raddr = {age_lv_ff, pos_ff[QPOS_W-1:0]};
            end else if (ag_last) begin
               fin = 1'b1;
            end else begin
               age_lv_in = age_lv_ff + 2'd1;
               pos_in    = '0;
            end
         end
         S_AG_Q: begin
            ent_id_in = q_rdata;
            if (id_ok(q_rdata)) begin
               p_req.raddr = PIX_W'(q_rdata);
            end else begin
               pos_in = pos_ff + 7'd1;
            end
         end
         S_AG_P: begin
            if (ag_old) begin
               if (ag_full) begin
                  if (ag_last) begin
                     fin = 1'b1;
                  end else begin
                     age_lv_in = age_lv_ff + 2'd1;
                     pos_in    = '0;
                  end
               end else begin
                  newlv_in = ag_nl;
                  lv_in    = age_lv_ff;
                  sh_v_in  = 1'b0;
                  ret_in   = S_AG_APP;
               end
            end else begin
               pos_in = pos_ff + 7'd1;
            end
         end
         S_AG_APP: begin
            q_req.we    = 1'b1;
            q_req.waddr = {newlv_ff, cnt_ff[newlv_ff][QPOS_W-1:0]};
            q_req.wdata = ent_id_ff;
            cnt_in[newlv_ff] = cnt_ff[newlv_ff] + 7'd1;
            p_req.we    = 1'b1;
            p_req.waddr = PIX_W'(ent_id_ff);
            p_req.wdata = '{level: newlv_ff, wait_cnt: '0};
            if (ag_last) begin
               fin = 1'b1;
            end else begin
               age_lv_in = age_lv_ff + 2'd1;
               pos_in    = '0;
            end
         end
         default: begin
         end
      endcase
      rsp_valid_in  = fin;
      rsp_gid_in    = (state_ff == S_IDLE) ? '0 : granted_ff;
      rsp_slice_in  = (state_ff == S_IDLE) ? '0 : slice_ff;
      rsp_status_in = fin_st;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         quant_ff     <= QUANT_RESET;
         cnt_ff       <= '{default: '0};
         active_ff    <= '0;
         pvalid_ff    <= '0;
         prv_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         quant_ff     <= quant_in;
         cnt_ff       <= cnt_in;
         active_ff    <= active_in;
         if (p_req.we) begin
            pvalid_ff[p_req.waddr] <= 1'b1;
         end
         prv_ff       <= pvalid_ff[p_req.raddr];
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff         <= id_in;
      burst_ff      <= burst_in;
      req_ff        <= req_in;
      lv_ff         <= lv_in;
      pos_ff        <= pos_in;
      walk_ff       <= walk_in;
      age_lv_ff     <= age_lv_in;
      ent_id_ff     <= ent_id_in;
      newlv_ff      <= newlv_in;
      granted_ff    <= granted_in;
      slice_ff      <= slice_in;
      sh_v_ff       <= sh_v_in;
      ret_ff        <= ret_in;
      if (fin) begin
         rsp_gid_ff    <= rsp_gid_in;
         rsp_slice_ff  <= rsp_slice_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_granted_id   = rsp_gid_ff;
   assign rsp_slice_length = rsp_slice_ff;
   assign rsp_status       = rsp_status_ff;

   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (rsp_valid_ff || busy))
      else $error("accepted item neither finished nor in progress");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == ST_EMPTY) |-> (rsp_gid_ff == '0 && rsp_slice_ff == '0))
      else $error("empty dispatch with nonzero grant");

   a_shift_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SH) |-> (pos_ff < cnt_ff[lv_ff]))
      else $error("queue shift past count");

   a_rsp_has_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ($past(state_ff) != S_IDLE || $past(start)))
      else $error("result without an item");

endmodule

### src/mlfq_scheduler_with_aging_top.sv
// Top level of the four-level feedback queue scheduler with aging.
//
//  channel   ports                                     handshake
//  request   req_op/proc_id/burst_cycles/requeue       start & !busy
//  result    rsp_granted_id/slice_length/status        rsp_valid strobe, one cycle
//  config    csr_data (base quantum)                   csr_valid & csr_ready
//
// Admit, exit and rejected items finish on accept, ready in S_RDY; the strobe is registered.
// Slice done walks the whole process table (S_SL_WALK), then S_SL_RD and S_SL_UPD.
// Dispatch pops the head of the first nonempty level and closes the gap (S_SH),
// then ages levels 1 to 3: per level, at most one old entry moves up a level.
// Synchronous active-high reset clears counts, active and valid bits at once.
// Results cannot be stalled; busy stays high until the result is strobed.
`timescale 1ns / 1ps
module mlfq_scheduler_with_aging_top import mlfq_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_op,
   input  logic [ID_W-1:0]    req_proc_id,
   input  logic [BURST_W-1:0] req_burst_cycles,
   input  logic               req_requeue,
   output logic               rsp_valid,
   output logic [ID_W-1:0]    rsp_granted_id,
   output logic [SLICE_W-1:0] rsp_slice_length,
   output logic [1:0]         rsp_status,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [QUANT_W-1:0] csr_data
);

   qmem_req_type      q_req;
   pmem_req_type      p_req;
   logic [ID_W-1:0]   q_rdata;
   logic [PENT_W-1:0] p_rdata_raw;
   pent_type          p_rdata;

   assign p_rdata = pent_type'(p_rdata_raw);

   mlfq_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_op           (req_op),
      .req_proc_id      (req_proc_id),
      .req_burst_cycles (req_burst_cycles),
      .req_requeue      (req_requeue),
      .rsp_valid        (rsp_valid),
      .rsp_granted_id   (rsp_granted_id),
      .rsp_slice_length (rsp_slice_length),
      .rsp_status       (rsp_status),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_data         (csr_data),
      .q_req            (q_req),
      .q_rdata          (q_rdata),
      .p_req            (p_req),
      .p_rdata          (p_rdata)
   );

   // level queues, addressed {level, position}
   mlfq_ram #(.DEPTH(QDEPTH), .WIDTH(ID_W)) u_qram (
      .clock (clock),
      .we    (q_req.we),
      .waddr (q_req.waddr),
      .wdata (q_req.wdata),
      .raddr (q_req.raddr),
      .rdata (q_rdata)
   );

   // process table: level and wait per process
   mlfq_ram #(.DEPTH(MAX_PROCS), .WIDTH(PENT_W)) u_pram (
      .clock (clock),
      .we    (p_req.we),
      .waddr (p_req.waddr),
      .wdata (p_req.wdata),
      .raddr (p_req.raddr),
      .rdata (p_rdata_raw)
   );

endmodule

### tb/sv/mlfq_checker.sv
// Checker for the feedback queue scheduler: predicts each result and compares it.
`timescale 1ns / 1ps
module mlfq_checker import mlfq_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic [2:0]         req_op,
   input  logic [ID_W-1:0]    req_proc_id,
   input  logic [BURST_W-1:0] req_burst_cycles,
   input  logic               req_requeue,
   input  logic               rsp_valid,
   input  logic [ID_W-1:0]    rsp_granted_id,
   input  logic [SLICE_W-1:0] rsp_slice_length,
   input  logic [1:0]         rsp_status,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [QUANT_W-1:0] csr_data,
   output int                 errors,
   output int                 pending
);

   typedef struct packed {
      logic [ID_W-1:0]    granted;
      logic [SLICE_W-1:0] slice;
      logic [1:0]         status;
   } sched_resp_type;

   logic [QUANT_W-1:0] quantum;
   logic [ID_W-1:0]    ready_fifo [NUM_LEVELS][64];
   int unsigned        fifo_count [NUM_LEVELS];
   logic [LEVEL_W-1:0] proc_lvl [MAX_PROCS];
   logic [WAIT_W-1:0]  proc_wt [MAX_PROCS];
   logic               proc_on [MAX_PROCS];
   sched_resp_type     sched_expected [$];

   initial errors = 0;
   assign pending = sched_expected.size();

   task automatic report(input string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      errors++;
   endtask

   function automatic bit push_ready(input int id);
      int lv;
      lv = proc_lvl[id];
      if (fifo_count[lv] >= 64) return 0;
      ready_fifo[lv][fifo_count[lv]] = id;
      fifo_count[lv]++;
      proc_wt[id] = '0;
      return 1;
   endfunction

   function automatic void drop_entry(input int lv, input int pos);
      for (int i = pos; i + 1 < fifo_count[lv]; i++)
         ready_fifo[lv][i] = ready_fifo[lv][i+1];
      fifo_count[lv]--;
   endfunction

   function automatic void age_level(input int lv);
      int id, plv, nlv;
      logic [31:0] lim;
      for (int i = 0; i < fifo_count[lv]; i++) begin
         id  = ready_fifo[lv][i];
         plv = proc_lvl[id];
         lim = 32'(quantum) * 32'd2 * 32'(plv + 1);
         if (proc_wt[id] >= lim) begin
            nlv = (plv != 0) ? plv - 1 : 0;
            if (fifo_count[nlv] >= 64) return;
            drop_entry(lv, i);
            proc_lvl[id] = nlv;
            void'(push_ready(id));
            return;
         end
      end
   endfunction

   function automatic sched_resp_type predict_schedule(input logic [2:0] op,
                                                       input int id,
                                                       input logic [BURST_W-1:0] burst,
                                                       input logic rq);
      sched_resp_type r;
      int lv;
      logic [WAIT_W:0] s;
      r = '0;
      r.status = ST_OK;
      if (op == OP_DISPATCH) begin
         lv = NUM_LEVELS;
         for (int i = NUM_LEVELS - 1; i >= 0; i--)
            if (fifo_count[i] != 0) lv = i;
         if (lv == NUM_LEVELS) begin
            r.status = ST_EMPTY;
         end else begin
            r.granted = ready_fifo[lv][0];
            drop_entry(lv, 0);
            r.slice = SLICE_W'(32'(quantum) * 32'(proc_lvl[r.granted] + 1));
            for (int i = 1; i < NUM_LEVELS; i++) age_level(i);
         end
      end else if (op > OP_EXIT || id >= MAX_PROCS) begin
         r.status = ST_ERR;
      end else if (op == OP_ADMIT) begin
         proc_on[id]  = 1'b1;
         proc_lvl[id] = LEVEL_TOP;
         proc_wt[id]  = '0;
      end else if (!proc_on[id]) begin
         r.status = ST_ERR;
      end else if (op == OP_READY) begin
         if (!push_ready(id)) r.status = ST_ERR;
      end else if (op == OP_SLICE) begin
         for (int i = 0; i < MAX_PROCS; i++)
            if (proc_on[i]) begin
               s = {1'b0, proc_wt[i]} + 33'(burst);
               proc_wt[i] = s[WAIT_W] ? '1 : s[WAIT_W-1:0];
            end
         lv = proc_lvl[id];
         if (lv < 3 && 32'(burst) >= 32'(quantum) * 32'(lv + 1))
            proc_lvl[id] = lv + 1;
         if (rq && !push_ready(id)) r.status = ST_ERR;
      end else begin
         proc_on[id] = 1'b0;
      end
      return r;
   endfunction

   always @(posedge clock) begin
      sched_resp_type exp_r;
      if (reset) begin
         quantum = QUANT_RESET;
         for (int i = 0; i < NUM_LEVELS; i++) fifo_count[i] = 0;
         for (int i = 0; i < MAX_PROCS; i++) begin
            proc_lvl[i] = '0;
            proc_wt[i]  = '0;
            proc_on[i]  = 1'b0;
         end
         sched_expected.delete();
      end else begin
         if (rsp_valid) begin
            if (sched_expected.size() == 0) begin
               report("result with no item outstanding");
            end else begin
               exp_r = sched_expected.pop_front();
               if (rsp_granted_id !== exp_r.granted)
                  report($sformatf("granted_id %0d, expected %0d",
                                   rsp_granted_id, exp_r.granted));
               if (rsp_slice_length !== exp_r.slice)
                  report($sformatf("slice_length %0d, expected %0d",
                                   rsp_slice_length, exp_r.slice));
               if (rsp_status !== exp_r.status)
                  report($sformatf("status %0d, expected %0d", rsp_status, exp_r.status));
            end
         end
         if (csr_valid && csr_ready) quantum = csr_data;
         if (start && !busy)
            sched_expected.push_back(predict_schedule(req_op, req_proc_id,
                                                      req_burst_cycles, req_requeue));
      end
   end

endmodule

### tb/sv/tb_mlfq_scheduler_with_aging_top.sv
// Testbench top: stimulus, quantum settings and verdict for the scheduler.
`timescale 1ns / 1ps
module tb_mlfq_scheduler_with_aging_top;
   import mlfq_pkg::*;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [2:0]         req_op = OP_ADMIT;
   logic [ID_W-1:0]    req_proc_id = '0;
   logic [BURST_W-1:0] req_burst_cycles = '0;
   logic               req_requeue = 1'b0;
   logic               rsp_valid;
   logic [ID_W-1:0]    rsp_granted_id;
   logic [SLICE_W-1:0] rsp_slice_length;
   logic [1:0]         rsp_status;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [QUANT_W-1:0] csr_data = '0;
   int                 errors, pending;
   int                 idle_pct = 0;
   logic [QUANT_W-1:0] cur_quantum = QUANT_RESET;

   always #2 clock = ~clock;

   mlfq_scheduler_with_aging_top uut (.*);

   mlfq_checker chk (.*);

   task automatic send(input logic [2:0] op, input logic [ID_W-1:0] id,
                       input logic [BURST_W-1:0] burst, input logic rq);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         start = 1'b0;
         @(negedge clock);
      end
      start            = 1'b1;
      req_op           = op;
      req_proc_id      = id;
      req_burst_cycles = burst;
      req_requeue      = rq;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
   endtask

   // drain, then let the block settle before touching the register
   task automatic set_quantum(input logic [QUANT_W-1:0] q);
      @(negedge clock);
      start = 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (800) @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_data  = q;
      forever begin
         @(posedge clock);
         if (csr_ready) break;
      end
      @(negedge clock);
      csr_valid   = 1'b0;
      cur_quantum = q;
   endtask

   task automatic random_items(input int n);
      int r;
      logic [2:0] op;
      logic [ID_W-1:0] id;
      logic [BURST_W-1:0] burst;
      for (int k = 0; k < n; k++) begin
         r  = $urandom_range(99);
         op = (r < 8)  ? OP_ADMIT : (r < 45) ? OP_READY : (r < 75) ? OP_DISPATCH :
              (r < 93) ? OP_SLICE : (r < 97) ? OP_EXIT : 3'($urandom_range(7, 5));
         id = ($urandom_range(99) < 80) ? ID_W'($urandom_range(15)) : ID_W'($urandom);
         r  = $urandom_range(99);
         if (r < 40) burst = BURST_W'($urandom_range(4 * cur_quantum + 2));
         else if (r < 70) burst = BURST_W'($urandom);
         else burst = BURST_W'($urandom_range(31));
         send(op, id, burst, 1'($urandom));
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: edges of ids, inactive and unknown ops, empty dispatch
      send(OP_DISPATCH, '0, '0, 1'b0);
      send(OP_ADMIT, 6'd0, '0, 1'b0);
      send(OP_ADMIT, 6'd63, '1, 1'b1);
      send(OP_READY, 6'd63, '0, 1'b0);
      send(OP_READY, 6'd5, '0, 1'b0);
      send(OP_SLICE, 6'd63, '1, 1'b1);
      send(OP_EXIT, 6'd63, '0, 1'b0);
      send(OP_READY, 6'd63, '0, 1'b0);
      send(OP_SLICE, 6'd63, 20'd5, 1'b1);
      send(3'd5, 6'd0, '0, 1'b0);
      send(3'd6, 6'd1, '0, 1'b1);
      send(3'd7, 6'd63, '1, 1'b1);
      send(OP_DISPATCH, '0, '0, 1'b0);
      send(OP_DISPATCH, '0, '0, 1'b0);
      send(OP_DISPATCH, '0, '0, 1'b0);
      // fill the level 0 queue past its capacity, then requeue into it
      send(OP_ADMIT, 6'd1, '0, 1'b0);
      for (int i = 0; i < 65; i++) send(OP_READY, 6'd1, '0, 1'b0);
      send(OP_SLICE, 6'd1, 20'd0, 1'b1);
      for (int i = 0; i < 66; i++) send(OP_DISPATCH, '0, '0, 1'b0);
      // wait counters grow large over many full slices
      send(OP_ADMIT, 6'd2, '0, 1'b0);
      for (int i = 0; i < 300; i++) send(OP_SLICE, 6'd2, '1, 1'b0);
      send(OP_READY, 6'd0, '0, 1'b0);
      send(OP_DISPATCH, '0, '0, 1'b0);

      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: set_quantum(12'd8);
            1: set_quantum(12'd1);
            2: set_quantum(12'd4095);
            3: set_quantum(12'd0);
            default: set_quantum(QUANT_W'($urandom_range(4095, 2)));
         endcase
         idle_pct = (ph % 3 == 0) ? 0 : (ph % 3 == 1) ? 83 : 7;
         random_items(220);
      end

      @(negedge clock);
      start = 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (800) @(posedge clock);
      if (errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #40_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

### files.f
src/mlfq_pkg.sv
src/mlfq_ram.sv
src/mlfq_ctrl.sv
src/mlfq_scheduler_with_aging_top.sv
tb/sv/mlfq_checker.sv
tb/sv/tb_mlfq_scheduler_with_aging_top.sv
